FILE: rtl/tsfc_pkg.sv
// Package: types, constants and register indexes for the touch sample filter
package tsfc_pkg;
	localparam int WINDOW_LEN    = 8;
	localparam int WIN_AW        = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
	localparam int DISPLAY_MAX_X = 479;
	localparam int DISPLAY_MAX_Y = 319;
	localparam int PADDR_W       = 5;

	localparam logic [2:0] REG_CAL_ENABLE  = 3'd0;
	localparam logic [2:0] REG_CAL_DIVISOR = 3'd1;
	localparam logic [2:0] REG_XCAL_CX     = 3'd2;
	localparam logic [2:0] REG_XCAL_CY     = 3'd3;
	localparam logic [2:0] REG_XCAL_OFF    = 3'd4;
	localparam logic [2:0] REG_YCAL_CX     = 3'd5;
	localparam logic [2:0] REG_YCAL_CY     = 3'd6;
	localparam logic [2:0] REG_YCAL_OFF    = 3'd7;

	typedef struct packed {
		logic        touch_down;
		logic [11:0] raw_x;
		logic [11:0] raw_y;
		logic [11:0] raw_z1;
		logic [11:0] raw_z2;
	} in_word_t;

	typedef struct packed {
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [15:0] pressure;
		logic        pressed;
		logic        pressure_invalid;
		logic        cal_fault;
	} out_word_t;

	typedef struct packed {
		logic cal_enable;
		logic signed [31:0] cal_divisor;
		logic signed [31:0] xcx;
		logic signed [31:0] xcy;
		logic signed [31:0] xoff;
		logic signed [31:0] ycx;
		logic signed [31:0] ycy;
		logic signed [31:0] yoff;
	} cal_regs_t;

	// controller -> datapath commands
	typedef struct packed {
		logic load;      // capture input word
		logic prep;      // form pressure numerator/denominator
		logic div_start; // start divider
		logic div_step;  // one divider bit
		logic p_done;    // finish pressure, update windows
		logic sum_clr;
		logic sum_step;
		logic avg;       // form averages
		logic cal_mul;   // one calibration multiply phase
		logic cal_sel_y; // working on y numerator
		logic cal_fin;   // finish calibrated coordinate
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic sum_last;
	} stat_t;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_PREP  = 10'b0000000010,
		ST_PDIV  = 10'b0000000100,
		ST_PFIN  = 10'b0000001000,
		ST_SUM   = 10'b0000010000,
		ST_AVG   = 10'b0000100000,
		ST_MUL   = 10'b0001000000,
		ST_CDIV  = 10'b0010000000,
		ST_CFIN  = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;
endpackage

FILE: rtl/touch_sample_filter_calibrate.sv
// Top level: touch sample filter with pressure estimate and calibration
//
// One raw sample word enters on in_valid/in_stall; one result word leaves on
// out_valid/out_stall for every sample. A sample passes through a 36-step
// restoring division for the pressure, one cycle per window entry for the
// averages (8), then two 66-step divisions for the calibrated x and y on the
// same shared divider, plus the control steps between them. The block works
// on one sample at a time and in_stall is high while it does. Calibration
// registers sit on an APB-style port, always ready; the user must write them
// only while the block is idle, as the block itself does not enforce it.
// Reset clears windows, held values, the ring slot and all calibration
// registers; the first press preloads every window entry. While the
// receiver stalls, the result word holds; a new sample is accepted and
// processed meanwhile, and its result waits in the datapath until the
// output register frees.
module touch_sample_filter_calibrate import tsfc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_word_t           in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_word_t          out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	cal_regs_t regs;
	cmd_t      cmd;
	stat_t     stat;

	tsfc_regs u_regs (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .regs
	);

	tsfc_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.stat, .cmd
	);

	tsfc_datapath u_dp (
		.clk, .arst_n, .in_word(in_data), .regs, .cmd, .stat,
		.out_word(out_data)
	);
endmodule

FILE: rtl/tsfc_ctrl.sv
// Controller: sequences pressure division, window sums and calibration
module tsfc_ctrl import tsfc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);
	state_t    state_q, state_d;
	logic [6:0] cnt_q, cnt_d;
	logic       sel_y_q, sel_y_d;
	logic       ovalid_q, ovalid_d;
	logic [1:0] mph_q, mph_d;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = ovalid_q;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		sel_y_d  = sel_y_q;
		mph_d    = mph_q;
		ovalid_d = ovalid_q && out_stall;
		cmd      = '0;
		cmd.cal_sel_y = sel_y_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				cmd.div_start = 1'b1;
				cnt_d   = 7'd0;
				state_d = ST_PDIV;
			end
			ST_PDIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 7'd1;
				if (cnt_q == 7'd35) state_d = ST_PFIN;
			end
			ST_PFIN: begin
				cmd.p_done  = 1'b1;
				cmd.sum_clr = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum_step = 1'b1;
				if (stat.sum_last) state_d = ST_AVG;
			end
			ST_AVG: begin
				cmd.avg = 1'b1;
				sel_y_d = 1'b0;
				mph_d   = 2'd0;
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.cal_mul = 1'b1;
				mph_d = mph_q + 2'd1;
				if (mph_q == 2'd2) begin
					cmd.div_start = 1'b1;
					cnt_d   = 7'd0;
					state_d = ST_CDIV;
				end
			end
			ST_CDIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 7'd1;
				if (cnt_q == 7'd65) state_d = ST_CFIN;
			end
			ST_CFIN: begin
				cmd.cal_fin = 1'b1;
				if (!sel_y_q) begin
					sel_y_d = 1'b1;
					mph_d   = 2'd0;
					state_d = ST_MUL;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// hold until the previous word has gone
				if (!ovalid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					ovalid_d = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			sel_y_q  <= 1'b0;
			mph_q    <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			sel_y_q  <= sel_y_d;
			mph_q    <= mph_d;
			ovalid_q <= ovalid_d;
		end
	end
endmodule

FILE: rtl/tsfc_datapath.sv
// Datapath: windows, pressure and calibration arithmetic, shared divider
module tsfc_datapath import tsfc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  in_word,
	input  cal_regs_t regs,
	input  cmd_t      cmd,
	output stat_t     stat,
	output out_word_t out_word
);
	in_word_t    in_q;
	logic        was_pressed_q;
	logic [11:0] held_x_q, held_y_q;
	logic [15:0] held_f_q;
	logic [11:0] xw_q [WINDOW_LEN];
	logic [11:0] yw_q [WINDOW_LEN];
	logic [15:0] fw_q [WINDOW_LEN];
	logic [WIN_AW-1:0] slot_q, rd_q;
	logic [WIN_AW+11:0] sx_q, sy_q;
	logic [WIN_AW+15:0] sf_q;
	logic [11:0] ax_q, ay_q;
	logic [15:0] af_q;
	logic        inval_q;

	// shared restoring divider on magnitudes
	logic [65:0] dnum_q;   // dividend magnitude, shifts out as quotient
	logic [65:0] drem_q;
	logic [31:0] dden_q;
	logic [66:0] dtrial;
	logic [65:0] pnum, pnum_d;

	// calibration: signed products
	logic signed [44:0] p1_q, p2_q;
	logic signed [65:0] cnum_q;
	logic [11:0] cx_q, cy_q;
	logic        dz;

	logic [11:0] zd;
	logic [23:0] xz;
	logic [35:0] pn;

	assign zd  = in_q.raw_z2 - in_q.raw_z1;
	assign xz  = in_q.raw_x * zd;
	assign pn  = {12'd0, xz} * 36'd4095;
	// align the 36-bit numerator to the top so 36 steps yield the quotient
	assign pnum = {pn, 30'd0};
	assign dz  = (regs.cal_divisor == 32'sd0);

	// numerator for the calibration divide
	logic signed [31:0] ccx, ccy, coff;
	logic signed [65:0] cabs_src;
	assign ccx  = cmd.cal_sel_y ? regs.ycx  : regs.xcx;
	assign ccy  = cmd.cal_sel_y ? regs.ycy  : regs.xcy;
	assign coff = cmd.cal_sel_y ? regs.yoff : regs.xoff;
	assign cabs_src = cnum_q[65] ? -cnum_q : cnum_q;
	logic [31:0] dabs;
	assign dabs = regs.cal_divisor[31] ? -regs.cal_divisor : regs.cal_divisor;
	assign pnum_d = cmd.prep ? pnum : cabs_src;

	assign dtrial = {drem_q, dnum_q[65]} - {35'd0, dden_q};

	logic [WIN_AW:0] rd_next;
	assign rd_next = {1'b0, rd_q} + 1'b1;
	assign stat.sum_last = (rd_q == WIN_AW'(WINDOW_LEN - 1));

	logic [WIN_AW-1:0] slot_next;
	assign slot_next = (slot_q == WIN_AW'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;

	// signed quotient, clamped to a display limit
	logic signed [66:0] q_s;
	logic [11:0] q_clamp;
	logic        neg_q;
	logic [11:0] lim;
	assign lim = cmd.cal_sel_y ? 12'(DISPLAY_MAX_Y) : 12'(DISPLAY_MAX_X);
	assign q_s = neg_q ? -$signed({1'b0, dnum_q}) : $signed({1'b0, dnum_q});
	assign q_clamp = (q_s < 0) ? 12'd0 :
		(q_s > $signed({55'd0, lim})) ? lim : q_s[11:0];

	logic [15:0] pres;
	assign pres = (dnum_q[65:16] != '0) ? 16'hFFFF : dnum_q[15:0];

	always_ff @(posedge clk) begin
		if (cmd.load) in_q <= in_word;
		if (cmd.div_start) begin
			dnum_q <= pnum_d;
			drem_q <= '0;
			dden_q <= cmd.prep ? {8'd0, in_q.raw_z1, 12'd0} : dabs;
			neg_q  <= cnum_q[65] ^ regs.cal_divisor[31];
		end else if (cmd.div_step) begin
			if (!dtrial[66]) begin
				drem_q <= dtrial[65:0];
				dnum_q <= {dnum_q[64:0], 1'b1};
			end else begin
				drem_q <= {drem_q[64:0], dnum_q[65]};
				dnum_q <= {dnum_q[64:0], 1'b0};
			end
		end
		if (cmd.sum_clr) begin
			sx_q <= '0; sy_q <= '0; sf_q <= '0;
		end else if (cmd.sum_step) begin
			sx_q <= sx_q + (WIN_AW+12)'(xw_q[rd_q]);
			sy_q <= sy_q + (WIN_AW+12)'(yw_q[rd_q]);
			sf_q <= sf_q + (WIN_AW+16)'(fw_q[rd_q]);
		end
		if (cmd.avg) begin
			ax_q <= 12'(sx_q / WINDOW_LEN);
			ay_q <= 12'(sy_q / WINDOW_LEN);
			af_q <= 16'(sf_q / WINDOW_LEN);
		end
		if (cmd.cal_mul) begin
			// phase: products, then sum
			p1_q   <= ccx * $signed({1'b0, ax_q});
			p2_q   <= ccy * $signed({1'b0, ay_q});
			cnum_q <= 66'(p1_q) + 66'(p2_q) + 66'(coff);
		end
		if (cmd.cal_fin) begin
			if (cmd.cal_sel_y) cy_q <= q_clamp;
			else               cx_q <= q_clamp;
		end
		if (cmd.out_load) begin
			out_word.pos_x <= regs.cal_enable ? (dz ? 12'd0 : cx_q) : ax_q;
			out_word.pos_y <= regs.cal_enable ? (dz ? 12'd0 : cy_q) : ay_q;
			out_word.pressure <= af_q;
			out_word.pressed  <= in_q.touch_down;
			out_word.pressure_invalid <= inval_q;
			out_word.cal_fault <= regs.cal_enable && dz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_pressed_q <= 1'b0;
			held_x_q <= '0; held_y_q <= '0; held_f_q <= '0;
			slot_q <= '0; rd_q <= '0; inval_q <= 1'b0;
			for (int i = 0; i < WINDOW_LEN; i++) begin
				xw_q[i] <= '0; yw_q[i] <= '0; fw_q[i] <= '0;
			end
		end else begin
			if (cmd.sum_clr) rd_q <= '0;
			else if (cmd.sum_step) rd_q <= rd_next[WIN_AW-1:0];
			if (cmd.p_done) begin
				logic [11:0] nx, ny;
				logic [15:0] nf;
				logic        iv;
				nx = held_x_q; ny = held_y_q; nf = held_f_q; iv = 1'b0;
				if (in_q.touch_down) begin
					nx = in_q.raw_x;
					ny = in_q.raw_y;
					if (in_q.raw_z1 == 12'd0) begin
						nf = 16'hFFFF; iv = 1'b1;
					end else if (in_q.raw_z2 <= in_q.raw_z1) nf = 16'd0;
					else nf = pres;
				end
				held_x_q <= nx; held_y_q <= ny; held_f_q <= nf;
				inval_q  <= iv;
				was_pressed_q <= in_q.touch_down;
				// preload all slots on a new press
				for (int i = 0; i < WINDOW_LEN; i++) begin
					if ((in_q.touch_down && !was_pressed_q) ||
					    (slot_q == WIN_AW'(i))) begin
						xw_q[i] <= nx; yw_q[i] <= ny; fw_q[i] <= nf;
					end
				end
				slot_q <= slot_next;
			end
		end
	end
endmodule

FILE: rtl/tsfc_regs.sv
// Configuration registers behind the APB-style port
module tsfc_regs import tsfc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cal_regs_t          regs
);
	logic [2:0] idx;
	assign idx    = paddr[4:2];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs <= '0;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
			case (idx)
				REG_CAL_ENABLE:  regs.cal_enable  <= pwdata[0];
				REG_CAL_DIVISOR: regs.cal_divisor <= pwdata;
				REG_XCAL_CX:     regs.xcx  <= pwdata;
				REG_XCAL_CY:     regs.xcy  <= pwdata;
				REG_XCAL_OFF:    regs.xoff <= pwdata;
				REG_YCAL_CX:     regs.ycx  <= pwdata;
				REG_YCAL_CY:     regs.ycy  <= pwdata;
				REG_YCAL_OFF:    regs.yoff <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CAL_ENABLE:  prdata = {31'd0, regs.cal_enable};
			REG_CAL_DIVISOR: prdata = regs.cal_divisor;
			REG_XCAL_CX:     prdata = regs.xcx;
			REG_XCAL_CY:     prdata = regs.xcy;
			REG_XCAL_OFF:    prdata = regs.xoff;
			REG_YCAL_CX:     prdata = regs.ycx;
			REG_YCAL_CY:     prdata = regs.ycy;
			REG_YCAL_OFF:    prdata = regs.yoff;
			default:         prdata = '0;
		endcase
	end
endmodule

FILE: bench/touch_sample_filter_calibrate_test.sv
// Testbench for the touch sample filter: queue-fed driver, monitor and scoreboard
`timescale 1ns / 1ps

module touch_sample_filter_calibrate_test;
	import tsfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 300;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_word_t           in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_word_t          out_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	touch_sample_filter_calibrate dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [11:0]        x_hist [WINDOW_LEN];
	logic [11:0]        y_hist [WINDOW_LEN];
	logic [15:0]        f_hist [WINDOW_LEN];
	int unsigned        slot;
	logic               prev_down;
	logic [11:0]        keep_x, keep_y;
	logic [15:0]        keep_f;
	logic               cal_on;
	logic signed [31:0] cal_regs [8];

	in_word_t           sample_queue [$];
	out_word_t          expected_words [$];
	int                 errors = 0;
	int                 accepted = 0;
	int                 stalled_cycles = 0;
	bit                 stim_done = 0;
	bit                 hold_off = 0;
	int                 in_gap = 0;
	int                 out_gap = 0;
	logic               in_stall_q = 1'b0;
	int                 next_gap = 0;

	function automatic logic [15:0] pressure_est(logic [11:0] x, logic [11:0] z1,
			logic [11:0] z2);
		longint unsigned num, q;
		if (z2 <= z1)
			return 16'd0;
		num = longint'(x) * longint'(z2 - z1) * 4095;
		q = num / (64'd4096 * z1);
		return (q > 65535) ? 16'hFFFF : q[15:0];
	endfunction

	function automatic logic [11:0] map_coord(logic signed [31:0] cx, logic signed [31:0] cy,
			logic signed [31:0] off, logic [11:0] x, logic [11:0] y, longint maxv);
		longint v;
		v = (longint'(cx) * longint'(x) + longint'(cy) * longint'(y) + longint'(off))
			/ longint'(cal_regs[REG_CAL_DIVISOR]);
		if (v < 0) v = 0;
		if (v > maxv) v = maxv;
		return v[11:0];
	endfunction

	function automatic out_word_t filter_sample(in_word_t s);
		out_word_t r;
		int unsigned sx, sy, sf;
		logic [11:0] ax, ay;
		r = '0;
		if (s.touch_down) begin
			keep_x = s.raw_x;
			keep_y = s.raw_y;
			if (s.raw_z1 == 0) begin
				keep_f = 16'hFFFF;
				r.pressure_invalid = 1'b1;
			end else begin
				keep_f = pressure_est(s.raw_x, s.raw_z1, s.raw_z2);
			end
			// preload on a fresh press
			if (!prev_down) begin
				for (int i = 0; i < WINDOW_LEN; i++) begin
					x_hist[i] = keep_x;
					y_hist[i] = keep_y;
					f_hist[i] = keep_f;
				end
			end
		end
		prev_down = s.touch_down;
		x_hist[slot] = keep_x;
		y_hist[slot] = keep_y;
		f_hist[slot] = keep_f;
		slot = (slot >= WINDOW_LEN - 1) ? 0 : slot + 1;
		sx = 0; sy = 0; sf = 0;
		for (int i = 0; i < WINDOW_LEN; i++) begin
			sx += x_hist[i];
			sy += y_hist[i];
			sf += f_hist[i];
		end
		ax = 12'(sx / WINDOW_LEN);
		ay = 12'(sy / WINDOW_LEN);
		r.pressure = 16'(sf / WINDOW_LEN);
		if (cal_on) begin
			if (cal_regs[REG_CAL_DIVISOR] == 0) begin
				r.cal_fault = 1'b1;
				ax = '0;
				ay = '0;
			end else begin
				r.pos_x = map_coord(cal_regs[REG_XCAL_CX], cal_regs[REG_XCAL_CY],
					cal_regs[REG_XCAL_OFF], ax, ay, DISPLAY_MAX_X);
				r.pos_y = map_coord(cal_regs[REG_YCAL_CX], cal_regs[REG_YCAL_CY],
					cal_regs[REG_YCAL_OFF], ax, ay, DISPLAY_MAX_Y);
				ax = r.pos_x;
				ay = r.pos_y;
			end
		end
		r.pos_x = ax;
		r.pos_y = ay;
		r.pressed = s.touch_down;
		return r;
	endfunction

	// driver: present words from the queue with random gaps
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall_q) begin
				if (in_gap == 0 && !hold_off && sample_queue.size() > 0 && next_gap == 0) begin
					in_data <= sample_queue.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end else if (!in_valid) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
				end else if (!hold_off && sample_queue.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= sample_queue.pop_front();
				end
			end
			out_stall <= (out_gap > 0);
			if (out_gap > 0) out_gap <= out_gap - 1;
		end
	end

	// monitor: sample handshakes at the rising edge
	always @(posedge clk) begin
		in_stall_q <= !(arst_n && in_valid && !in_stall);
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_words.push_back(filter_sample(in_data));
				accepted <= accepted + 1;
				next_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
				in_gap <= (next_gap > 0) ? next_gap - 1 : 0;
			end
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected result word %p", $time, out_data);
					errors <= errors + 1;
				end else if (out_data !== expected_words[0]) begin
					$display("%0t: expected %p actual %p", $time, expected_words[0], out_data);
					errors <= errors + 1;
					void'(expected_words.pop_front());
				end else begin
					void'(expected_words.pop_front());
				end
				if (out_gap == 0 && $urandom_range(0, 2) != 0)
					out_gap <= $urandom_range(0, 12);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stalled_cycles <= 0;
			else
				stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= PADDR_W'(idx) << 2; pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == REG_CAL_ENABLE) cal_on = val[0];
		else cal_regs[idx] = val;
	endtask

	task automatic wait_idle();
		while (sample_queue.size() > 0 || in_valid || expected_words.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic in_word_t rand_sample(bit down_bias);
		in_word_t s;
		s.touch_down = down_bias ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1));
		s.raw_x = 12'($urandom);
		s.raw_y = 12'($urandom);
		case ($urandom_range(0, 7))
			0: s.raw_z1 = 12'd0;
			1: s.raw_z1 = 12'hFFF;
			2: s.raw_z1 = 12'($urandom_range(1, 8));
			default: s.raw_z1 = 12'($urandom);
		endcase
		case ($urandom_range(0, 5))
			0: s.raw_z2 = s.raw_z1;
			1: s.raw_z2 = 12'hFFF;
			default: s.raw_z2 = 12'($urandom);
		endcase
		return s;
	endfunction

	task automatic random_cal();
		reg_write(REG_CAL_DIVISOR, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 16)
			* (($urandom_range(0, 1) != 0) ? 1 : -1));
		for (int r = REG_XCAL_CX; r <= REG_YCAL_OFF; r++)
			reg_write(r[2:0], ($urandom_range(0, 5) == 0) ? $urandom
				: 32'($signed($urandom_range(0, 4000)) - 2000));
	endtask

	initial begin
		for (int i = 0; i < WINDOW_LEN; i++) begin
			x_hist[i] = 0; y_hist[i] = 0; f_hist[i] = 0;
		end
		slot = 0; prev_down = 0; keep_x = 0; keep_y = 0; keep_f = 0; cal_on = 0;
		for (int i = 0; i < 8; i++) cal_regs[i] = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes and the special cases, calibration off
		sample_queue.push_back('{1'b0, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF});
		sample_queue.push_back('{1'b1, 12'hFFF, 12'hFFF, 12'd0, 12'hFFF});
		sample_queue.push_back('{1'b1, 12'hFFF, 12'd0, 12'd1, 12'hFFF});
		sample_queue.push_back('{1'b1, 12'd100, 12'd200, 12'd500, 12'd400});
		sample_queue.push_back('{1'b1, 12'd0, 12'hFFF, 12'd300, 12'd300});
		sample_queue.push_back('{1'b0, 12'd0, 12'd0, 12'd0, 12'd0});
		sample_queue.push_back('{1'b1, 12'd2000, 12'd1000, 12'd800, 12'd3000});
		for (int i = 0; i < 10; i++)
			sample_queue.push_back('{1'b1, 12'(i * 400), 12'(4095 - i * 400), 12'd600,
				12'd2400});
		wait_idle();

		// zero divisor with calibration on
		reg_write(REG_CAL_ENABLE, 1);
		reg_write(REG_CAL_DIVISOR, 0);
		sample_queue.push_back('{1'b1, 12'd1234, 12'd2345, 12'd100, 12'd900});
		sample_queue.push_back('{1'b0, 12'd0, 12'd0, 12'd0, 12'd0});
		wait_idle();

		// extreme coefficients
		reg_write(REG_CAL_DIVISOR, 32'h8000_0000);
		reg_write(REG_XCAL_CX, 32'h7FFF_FFFF);
		reg_write(REG_XCAL_CY, 32'h8000_0000);
		reg_write(REG_XCAL_OFF, 32'h7FFF_FFFF);
		reg_write(REG_YCAL_CX, 32'h8000_0000);
		reg_write(REG_YCAL_CY, 32'h7FFF_FFFF);
		reg_write(REG_YCAL_OFF, 32'h8000_0000);
		for (int i = 0; i < 4; i++) sample_queue.push_back(rand_sample(1));
		wait_idle();
		reg_write(REG_CAL_DIVISOR, 32'h7FFF_FFFF);
		for (int i = 0; i < 4; i++) sample_queue.push_back(rand_sample(1));
		wait_idle();

		// random phases, each with its own calibration setting
		for (int ph = 0; ph < 10; ph++) begin
			reg_write(REG_CAL_ENABLE, (ph % 3) != 0);
			random_cal();
			for (int i = 0; i < 100; i++) begin
				sample_queue.push_back(rand_sample((ph % 4) != 3));
				if (i == 50 && ph == 4) begin
					// hold the sender until the pipeline is empty
					while (sample_queue.size() > 0 || in_valid) @(posedge clk);
					hold_off = 1;
					while (expected_words.size() > 0) @(posedge clk);
					hold_off = 0;
				end
			end
			wait_idle();
		end
		stim_done = 1;
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
